>>> design/arpt_pkg.sv
// ----------------------------------------------------------------------------
// ARP table package
// Types and constants shared by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package arpt_pkg;

    localparam int SLOT_W = 5;
    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int AGE_W = 16;
    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd15;
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_RESET = 16'h0001;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_RESP,
        ST_TICK,
        ST_PLACE,
        ST_MOD
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cmd_t;

endpackage

>>> design/arpt_front.sv
// ----------------------------------------------------------------------------
// ARP table front end
// Accepts input words, decodes the operation and holds them in a two-entry
// queue in front of the back end.
// ----------------------------------------------------------------------------
module arpt_front
    import arpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_op,
    input  logic [IP_W-1:0]  in_ip,
    input  logic [MAC_W-1:0] in_mac,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    op_t        op_dec;

    always_comb
    begin
        unique case (in_op)
            OP_LOOKUP: op_dec = OP_LOOKUP;
            OP_INSERT: op_dec = OP_INSERT;
            OP_TICK:   op_dec = OP_TICK;
            default:   op_dec = OP_NONE;
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op_dec, ip: in_ip, mac: in_mac};
        end
    end

endmodule

>>> design/arpt_back.sv
// ----------------------------------------------------------------------------
// ARP table back end
// Holds the table and runs lookups, inserts and aging ticks, one command at a
// time, into an output register.
// ----------------------------------------------------------------------------
module arpt_back
    import arpt_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [AGE_W-1:0]  cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              res_hit,
    output logic [MAC_W-1:0]  res_mac,
    output logic [SLOT_W-1:0] res_slot
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int RECIP_SH = 16 + IDX_W;
    localparam logic [16:0] RECIP =
        17'(((64'd1 << RECIP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cmd_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IP_W-1:0]    ip_reg [ENTRIES];
    logic [AGE_W-1:0]   stamp_reg [ENTRIES];
    logic [MAC_W-1:0]   mac_mem [ENTRIES];
    logic [MAC_W-1:0]   mac_rd_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [AGE_W-1:0]   now_reg;
    logic [AGE_W-1:0]   now_next;
    logic [15:0]        lfsr_reg;
    logic [15:0]        lfsr_next;
    logic [AGE_W-1:0]   age_limit_reg;
    logic [15:0]        div_reg;
    logic [15:0]        quot_reg;
    logic [32:0]        recip_prod;
    logic [15:0]        rem_full;
    logic [IDX_W-1:0]   rem_step;
    logic               cnt_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [MAC_W-1:0]   out_mac_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [ENTRIES-1:0] eq_vec;
    logic [ENTRIES-1:0] expire_vec;
    logic [IDX_W-1:0]   first_idx;
    logic               any_set;
    logic               out_free;
    logic               pop;
    logic               res_load;
    logic               load_hit;
    logic [MAC_W-1:0]   load_mac;
    logic [SLOT_W-1:0]  load_slot;
    logic               ins_we;
    logic [IDX_W-1:0]   ins_idx;
    logic               lfsr_step;
    logic               expire_en;

    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign pop       = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cmd_ready = pop;
    assign first_idx = first_set(match_reg);
    assign any_set   = |match_reg;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            eq_vec[i]     = valid_reg[i] && (ip_reg[i] == cmd.ip);
            expire_vec[i] = valid_reg[i] &&
                            (AGE_W'(now_reg - stamp_reg[i]) >= age_limit_reg);
        end
    end

    // The quotient comes from a multiply by the rounded-up reciprocal, which
    // is exact for every 16-bit value; the remainder follows in the next cycle.
    assign recip_prod = 33'(div_reg) * 33'(RECIP);

    always_comb
    begin
        rem_full = div_reg - 16'(quot_reg * 16'(ENTRIES));
        rem_step = rem_full[IDX_W-1:0];
    end

    assign lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_MASK : 16'h0000);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (cmd.op)
                        OP_LOOKUP: state_next = ST_FIND;
                        OP_INSERT: state_next = ST_PLACE;
                        OP_TICK:   state_next = ST_TICK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIND:  state_next = ST_RESP;
            ST_RESP:  state_next = ST_IDLE;
            ST_TICK:  state_next = ST_IDLE;
            ST_PLACE: state_next = any_set ? ST_IDLE : ST_MOD;
            ST_MOD:   state_next = cnt_reg ? ST_IDLE : ST_MOD;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_load  = 1'b0;
        load_hit  = 1'b0;
        load_mac  = '0;
        load_slot = '0;
        ins_we    = 1'b0;
        ins_idx   = first_idx;
        lfsr_step = 1'b0;
        expire_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                res_load = pop && (cmd.op == OP_NONE);
            end
            ST_RESP:
            begin
                res_load  = 1'b1;
                load_hit  = hit_reg;
                load_mac  = hit_reg ? mac_rd_reg : '0;
                load_slot = hit_reg ? SLOT_W'(idx_reg) : '0;
            end
            ST_TICK:
            begin
                res_load  = 1'b1;
                expire_en = 1'b1;
            end
            ST_PLACE:
            begin
                if (any_set)
                begin
                    ins_we    = 1'b1;
                    res_load  = 1'b1;
                    load_slot = SLOT_W'(first_idx);
                end
                else
                begin
                    lfsr_step = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (cnt_reg)
                begin
                    ins_we    = 1'b1;
                    ins_idx   = rem_step;
                    res_load  = 1'b1;
                    load_slot = SLOT_W'(rem_step);
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (expire_en)
        begin
            valid_next = valid_reg & ~expire_vec;
        end
        if (ins_we)
        begin
            valid_next[ins_idx] = 1'b1;
        end
        match_next = (cmd.op == OP_LOOKUP) ? eq_vec : ~valid_reg;
        now_next   = (pop && (cmd.op == OP_TICK)) ? now_reg + AGE_W'(1) : now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            now_reg       <= '0;
            lfsr_reg      <= LFSR_RESET;
            age_limit_reg <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            now_reg   <= now_next;
            if (lfsr_step)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cfg_we)
            begin
                age_limit_reg <= cfg_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg   <= cmd;
            match_reg <= match_next;
        end
        if (state_reg == ST_FIND)
        begin
            idx_reg    <= first_idx;
            hit_reg    <= any_set;
            mac_rd_reg <= mac_mem[first_idx];
        end
        if (lfsr_step)
        begin
            div_reg <= lfsr_next;
            cnt_reg <= 1'b0;
        end
        else if (state_reg == ST_MOD)
        begin
            quot_reg <= 16'(recip_prod >> RECIP_SH);
            cnt_reg  <= 1'b1;
        end
        if (ins_we)
        begin
            ip_reg[ins_idx]    <= cmd_reg.ip;
            stamp_reg[ins_idx] <= now_reg;
            mac_mem[ins_idx]   <= cmd_reg.mac;
        end
        if (res_load)
        begin
            out_hit_reg  <= load_hit;
            out_mac_reg  <= load_mac;
            out_slot_reg <= load_slot;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_hit   = out_hit_reg;
    assign res_mac   = out_mac_reg;
    assign res_slot  = out_slot_reg;

endmodule

>>> design/arp_table_with_aging.sv
// ----------------------------------------------------------------------------
// ARP table with aging
// IPv4-to-MAC table of ENTRIES slots with lookup, insert and tick-driven aging.
// ----------------------------------------------------------------------------
// Each input word is a lookup, an insert, a tick or an unknown operation;
// each gives exactly one output word. Commands are queued two deep and then
// executed one at a time by the table engine. A lookup runs a parallel
// compare, a priority pick with MAC memory read and a response. An insert
// fills the first free slot; when the table is full, the victim slot is the
// LFSR value reduced modulo ENTRIES by a reciprocal multiply and, in the
// next cycle, a subtract. An unknown operation leaves the table alone and
// answers with zeros. The engine starts the next command in the cycle after
// the previous result is loaded, and only while the output register is free
// or being read. The age limit register resets to 15 and is written through
// the cfg port.
module arp_table_with_aging
    import arpt_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // ip_address[31:0], mac_address[79:32]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // found_mac[47:0], slot_index[52:48], zero
    output logic        m_axis_tuser    // hit[0]
);

    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;
    logic [MAC_W-1:0]  res_mac;
    logic [SLOT_W-1:0] res_slot;

    assign cfg_ready = 1'b1;

    arpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_ip     (s_axis_tdata[31:0]),
        .in_mac    (s_axis_tdata[79:32]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    arpt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_hit   (m_axis_tuser),
        .res_mac   (res_mac),
        .res_slot  (res_slot)
    );

    assign m_axis_tdata = {3'b000, res_slot, res_mac};

endmodule

>>> design/arpt_checker.sv
// ----------------------------------------------------------------------------
// ARP table port checker
// Watches the top-level ports and flags words that break the block's rules.
// ----------------------------------------------------------------------------
module arpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0)
        else $error("MAC is nonzero on a word without a hit");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:53] == 3'd0)
        else $error("padding bits of the output word are not zero");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind arp_table_with_aging arpt_checker u_arpt_checker (.*);

>>> bench/tb_arp_table_with_aging.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP table with aging testbench
// Drives lookup, insert, tick and unknown words into the table and checks each
// output word against an in-bench cycle-free table model, or for some directed
// words against a fixed reply. Random phases, each under its own age limit,
// follow a short directed table; one has a tick run under the longest limit.
// ----------------------------------------------------------------------------
module tb_arp_table_with_aging
    import arpt_pkg::*;
();

    localparam int TB_ENTRIES = 32;
    localparam int POOL_SIZE = 40;
    localparam int N_DIR = 23;
    localparam int HOLD_CYCLES = 400;
    localparam int TICK_RUN = 30;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic [SLOT_W-1:0] slot;
    } arp_reply_t;

    typedef struct {
        op_t               op;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        int                reps;
        bit                fixed;
        logic              want_hit;
        logic [MAC_W-1:0]  want_mac;
        logic [SLOT_W-1:0] want_slot;
    } dir_row_t;

    typedef enum int {
        BURST_INSERT,
        BURST_LOOKUP,
        BURST_TICK,
        BURST_NOISE
    } burst_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // ip_address[31:0], mac_address[79:32]
    logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // found_mac[47:0], slot_index[52:48], zero
    logic        m_axis_tuser;        // hit[0]

    logic             tbl_valid [TB_ENTRIES];
    logic [IP_W-1:0]  tbl_ip [TB_ENTRIES];
    logic [MAC_W-1:0] tbl_mac [TB_ENTRIES];
    logic [AGE_W-1:0] tbl_stamp [TB_ENTRIES];
    logic [AGE_W-1:0] now_sec;
    logic [15:0]      victim_lfsr;
    logic [AGE_W-1:0] age_lim;

    arp_reply_t       reply_q [$];
    logic [IP_W-1:0]  ip_pool [POOL_SIZE];
    int               err_count = 0;
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    bit               rx_hold_req = 1'b0;

    dir_row_t dir_rows [N_DIR] = '{
        '{OP_LOOKUP, 32'h0000_0000, 48'h0, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'h0000_0000, 48'h0, 1, 1'b1, 1'b0, 48'h0, 5'd1},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 5'd0},
        '{OP_LOOKUP, 32'h0000_0000, 48'h0, 1, 1'b1, 1'b1, 48'h0, 5'd1},
        '{OP_INSERT, 32'h0000_0000, 48'h1234_5678_9ABC, 1, 1'b1, 1'b0, 48'h0, 5'd2},
        '{OP_LOOKUP, 32'h0000_0000, 48'h0, 1, 1'b1, 1'b1, 48'h0, 5'd1},
        '{OP_TICK,   32'h0000_0000, 48'h0, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_NONE,   32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'h0A00_0001, 48'h0, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'hC0A8_0100, 48'h0200_0000_0100, 29, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'hC0A8_0200, 48'h0000_DEAD_BEEF, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'hC0A8_0300, 48'h8000_0000_0300, 4, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'hC0A8_0105, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'hC0A8_0200, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_TICK,   32'h0000_0000, 48'h0, 14, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'h0000_0000, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_TICK,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 1'b1, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'hC0A8_0110, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_INSERT, 32'h7F00_0001, 48'h8000_0000_0001, 1, 1'b0, 1'b0, 48'h0, 5'd0},
        '{OP_LOOKUP, 32'h7F00_0001, 48'h0, 1, 1'b0, 1'b0, 48'h0, 5'd0}
    };

    arp_table_with_aging #(
        .ENTRIES(TB_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(3, 1);
        else if (roll < 95)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic logic [IP_W-1:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_stamp[i] = '0;
        end
        now_sec = '0;
        victim_lfsr = LFSR_RESET;
        age_lim = AGE_LIMIT_RESET;
    endfunction

    // Applies one command to the bench copy of the table and returns the word
    // that the block has to answer with.
    function automatic arp_reply_t predict_reply(op_t op, logic [IP_W-1:0] ip,
                                                 logic [MAC_W-1:0] mac);
        arp_reply_t r;
        int slot;
        logic [AGE_W-1:0] age;
        r = '0;
        slot = -1;
        case (op)
            OP_LOOKUP:
            begin
                for (int i = 0; i < TB_ENTRIES; i++)
                begin
                    if (slot < 0 && tbl_valid[i] && tbl_ip[i] == ip)
                    begin
                        slot = i;
                        r.hit = 1'b1;
                        r.mac = tbl_mac[i];
                        r.slot = SLOT_W'(i);
                    end
                end
            end
            OP_INSERT:
            begin
                for (int i = 0; i < TB_ENTRIES; i++)
                begin
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                end
                if (slot < 0)
                begin
                    victim_lfsr = {1'b0, victim_lfsr[15:1]}
                                  ^ (victim_lfsr[0] ? LFSR_MASK : 16'h0000);
                    slot = int'(victim_lfsr) % TB_ENTRIES;
                end
                tbl_valid[slot] = 1'b1;
                tbl_ip[slot] = ip;
                tbl_mac[slot] = mac;
                tbl_stamp[slot] = now_sec;
                r.slot = SLOT_W'(slot);
            end
            OP_TICK:
            begin
                now_sec = now_sec + 1'b1;
                for (int i = 0; i < TB_ENTRIES; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        age = now_sec - tbl_stamp[i];
                        if (age >= age_lim)
                        begin
                            tbl_valid[i] = 1'b0;
                            tbl_ip[i] = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // The valid is left high after the accepting edge so that a word that
    // follows without a gap keeps it high.
    task automatic send_cmd(op_t op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                            bit use_fixed, arp_reply_t fixed_reply);
        int gap;
        arp_reply_t pred;
        gap = (tx_idle_on && $urandom_range(1) == 1) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {mac, ip};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = predict_reply(op, ip, mac);
        reply_q.push_back(use_fixed ? fixed_reply : pred);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_age_limit(logic [AGE_W-1:0] value);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        age_lim = value;
    endtask

    // Random traffic in bursts: fills of the table mostly from a small address
    // pool, lookups mostly of pooled addresses, runs of ticks, and some noise.
    task automatic run_random(int n_items);
        int sent;
        int burst;
        burst_t kind;
        op_t op;
        logic [IP_W-1:0] ip;
        int roll;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                kind = BURST_INSERT;
                burst = $urandom_range(40, 1);
            end
            else if (roll < 70)
            begin
                kind = BURST_LOOKUP;
                burst = $urandom_range(12, 1);
            end
            else if (roll < 90)
            begin
                kind = BURST_TICK;
                burst = $urandom_range(5, 1);
            end
            else
            begin
                kind = BURST_NOISE;
                burst = $urandom_range(4, 1);
            end
            for (int k = 0; k < burst; k++)
            begin
                case (kind)
                    BURST_INSERT:
                    begin
                        op = OP_INSERT;
                        ip = ($urandom_range(9) < 7) ? pool_ip() : IP_W'($urandom);
                    end
                    BURST_LOOKUP:
                    begin
                        op = OP_LOOKUP;
                        ip = ($urandom_range(4) == 0) ? IP_W'($urandom) : pool_ip();
                    end
                    BURST_TICK:
                    begin
                        op = OP_TICK;
                        ip = IP_W'($urandom);
                    end
                    default:
                    begin
                        op = op_t'($urandom_range(3));
                        ip = ($urandom_range(1) == 1) ? pool_ip() : IP_W'($urandom);
                    end
                endcase
                send_cmd(op, ip, rand_mac(), 1'b0, '0);
            end
            sent += burst;
        end
    endtask

    initial
    begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : rx_side
        int rx_wait;
        bit hold_taken;
        arp_reply_t want;
        arp_reply_t got;
        rx_wait = 0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[52:48]};
                if (reply_q.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", got));
                else
                begin
                    want = reply_q.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
                    if (got.mac !== want.mac)
                        report_mismatch($sformatf("found_mac %h, want %h",
                                                  got.mac, want.mac));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot_index %0d, want %0d",
                                                  got.slot, want.slot));
                end
            end
            if (rx_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(3) == 0)
                    rx_wait = idle_len();
            end
        end
    end

    initial
    begin : tx_side
        arp_reply_t fixed_reply;
        reset_table();
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = IP_W'($urandom);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            fixed_reply = {dir_rows[r].want_hit, dir_rows[r].want_mac,
                           dir_rows[r].want_slot};
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_cmd(dir_rows[r].op, dir_rows[r].ip + IP_W'(k),
                         dir_rows[r].mac + MAC_W'(k), dir_rows[r].fixed, fixed_reply);
        end

        // With a zero limit every tick empties the table. The receiver also
        // holds off here long enough for the block to refuse input.
        write_age_limit(16'd0);
        rx_hold_req = 1'b1;
        run_random(60);

        write_age_limit(16'd1);
        run_random(60);

        write_age_limit(16'd3);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(80);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        write_age_limit(AGE_W'($urandom_range(40, 4)));
        run_random(80);

        // A run of ticks under the longest limit, where nothing may expire.
        write_age_limit(16'hFFFF);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < 6; k++)
            send_cmd(OP_INSERT, pool_ip(), rand_mac(), 1'b0, '0);
        for (int k = 0; k < TICK_RUN; k++)
            send_cmd(OP_TICK, IP_W'($urandom), rand_mac(), 1'b0, '0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(40);

        write_age_limit(16'd2);
        run_random(70);

        write_age_limit(AGE_LIMIT_RESET);
        run_random(60);

        drain_pipe();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
design/arpt_pkg.sv
design/arpt_front.sv
design/arpt_back.sv
design/arp_table_with_aging.sv
design/arpt_checker.sv
bench/tb_arp_table_with_aging.sv
